// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module of the scrubber.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define CRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define CRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/crs_pkg.sv =====
// Types, constants and field layout shared by the register scrubber modules.
`default_nettype none

package crs_pkg;

  // Default table depth
  localparam int TABLE_DEPTH_DEFAULT = 16;

  // Stream widths, packed and filled to whole bytes
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 56;

  // Opcodes carried on s_tuser
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  // Configuration register indexes
  localparam logic [0:0] REG_CHECK_DIVIDER  = 1'b0;
  localparam logic [0:0] REG_TABLE_CAPACITY = 1'b1;

  // One decoded input request
  typedef struct packed {
    logic       opcode;
    logic [7:0] bank_num;
    logic [7:0] reg_num;
    logic [7:0] expected_value;
    logic       bank_ok;
    logic       first_read_ok;
    logic [7:0] first_read_value;
    logic       second_read_ok;
    logic [7:0] second_read_value;
  } item_t;

  // One table entry
  typedef struct packed {
    logic [7:0] bank_num;
    logic [7:0] reg_num;
    logic [7:0] value;
  } entry_t;

  // One result
  typedef struct packed {
    logic       healthy;
    logic       compared;
    logic       dropped;
    logic       rewrite_request;
    logic [7:0] fail_bank;
    logic [7:0] fail_reg;
    logic [7:0] fail_value;
    logic [7:0] restore_value;
    logic [7:0] pending_bank;
    logic [7:0] pending_reg;
  } result_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_FETCH,
    ST_EVAL,
    ST_PEND,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/crs_table_mem.sv =====
// Entry table: one write port, one registered read port.
`default_nettype none

module crs_table_mem #(
  parameter int DEPTH  = crs_pkg::TABLE_DEPTH_DEFAULT,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output crs_pkg::entry_t        rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire crs_pkg::entry_t   wr_data
);

  crs_pkg::entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/crs_seq.sv =====
// Sequencer: table search, append, round-robin check and result assembly.
`default_nettype none

module crs_seq #(
  parameter int TABLE_DEPTH = crs_pkg::TABLE_DEPTH_DEFAULT,
  parameter int IDX_W       = 4,
  parameter int CNT_W       = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // request side
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire crs_pkg::item_t   in_item,
  // configuration
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [7:0]       cfg_data,
  // result side
  output logic                  res_valid,
  input  wire logic             res_ready,
  output crs_pkg::result_t      res,
  // table memory
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  wire crs_pkg::entry_t  rd_data,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output crs_pkg::entry_t       wr_data
);

  crs_pkg::state_t  state, state_next;
  crs_pkg::item_t   item, item_next;
  logic [CNT_W-1:0] used, used_next;
  logic [IDX_W-1:0] pointer, pointer_next;
  logic [7:0]       tick, tick_next;
  logic [7:0]       divider, divider_next;
  logic [4:0]       capacity, capacity_next;
  logic [23:0]      last_failure, last_failure_next;
  logic [CNT_W-1:0] scan, scan_next;
  logic             cmp_valid, cmp_valid_next;
  logic [IDX_W-1:0] cmp_idx, cmp_idx_next;
  logic             healthy, healthy_next;
  logic             compared, compared_next;
  logic             dropped, dropped_next;
  logic             rewrite, rewrite_next;
  logic [7:0]       restore, restore_next;

  // Helpers
  logic [8:0]       tick_inc;
  logic             fire;
  logic             full;
  logic [CNT_W:0]   ptr_inc;
  logic             issue;
  logic             match;
  logic             first_bad;
  logic             second_bad;

  assign tick_inc = {1'b0, tick} + 9'd1;
  assign fire     = tick_inc >= {1'b0, divider};
  assign full     = ({{(9-CNT_W){1'b0}}, used} >= {4'b0, capacity}) ||
                    ({{(9-CNT_W){1'b0}}, used} >= 9'(TABLE_DEPTH));
  assign ptr_inc  = (CNT_W+1)'(pointer) + (CNT_W+1)'(1);
  assign issue    = scan < used;
  assign match    = cmp_valid && (rd_data.bank_num == item.bank_num) &&
                    (rd_data.reg_num == item.reg_num);
  assign first_bad  = !item.first_read_ok || (item.first_read_value != rd_data.value);
  assign second_bad = !item.second_read_ok || (item.second_read_value != rd_data.value);

  // Result fields
  always_comb begin
    res.healthy         = healthy;
    res.compared        = compared;
    res.dropped         = dropped;
    res.rewrite_request = rewrite;
    res.fail_bank       = last_failure[23:16];
    res.fail_reg        = last_failure[15:8];
    res.fail_value      = last_failure[7:0];
    res.restore_value   = restore;
    res.pending_bank    = (used != '0) ? rd_data.bank_num : 8'd0;
    res.pending_reg     = (used != '0) ? rd_data.reg_num : 8'd0;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used         <= '0;
      pointer      <= '0;
      tick         <= '0;
      divider      <= '0;
      capacity     <= '0;
      last_failure <= '0;
      cmp_valid    <= 1'b0;
    end else begin
      used         <= used_next;
      pointer      <= pointer_next;
      tick         <= tick_next;
      divider      <= divider_next;
      capacity     <= capacity_next;
      last_failure <= last_failure_next;
      cmp_valid    <= cmp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item     <= item_next;
    scan     <= scan_next;
    cmp_idx  <= cmp_idx_next;
    healthy  <= healthy_next;
    compared <= compared_next;
    dropped  <= dropped_next;
    rewrite  <= rewrite_next;
    restore  <= restore_next;
  end

  // Next state and outputs
  always_comb begin
    state_next        = state;
    item_next         = item;
    used_next         = used;
    pointer_next      = pointer;
    tick_next         = tick;
    divider_next      = divider;
    capacity_next     = capacity;
    last_failure_next = last_failure;
    scan_next         = scan;
    cmp_valid_next    = cmp_valid;
    cmp_idx_next      = cmp_idx;
    healthy_next      = healthy;
    compared_next     = compared;
    dropped_next      = dropped;
    rewrite_next      = rewrite;
    restore_next      = restore;
    in_ready          = 1'b0;
    cfg_ready         = 1'b0;
    res_valid         = 1'b0;
    rd_en             = 1'b0;
    rd_addr           = pointer;
    wr_en             = 1'b0;
    wr_addr           = cmp_idx;
    wr_data.bank_num  = item.bank_num;
    wr_data.reg_num   = item.reg_num;
    wr_data.value     = item.expected_value;

    unique case (state)
      crs_pkg::ST_IDLE: begin
        // a register write goes first; a request waits behind it
        in_ready  = !cfg_valid;
        cfg_ready = 1'b1;
        // register writes
        if (cfg_valid) begin
          unique case (cfg_index)
            crs_pkg::REG_CHECK_DIVIDER: begin
              divider_next = cfg_data;
              tick_next    = '0;
            end
            crs_pkg::REG_TABLE_CAPACITY: begin
              capacity_next = cfg_data[4:0];
              used_next     = '0;
              pointer_next  = '0;
              tick_next     = '0;
            end
          endcase
        end else if (in_valid) begin
          // new request
          item_next     = in_item;
          healthy_next  = 1'b1;
          compared_next = 1'b0;
          dropped_next  = 1'b0;
          rewrite_next  = 1'b0;
          restore_next  = 8'd0;
          if (in_item.opcode == crs_pkg::OP_RECORD) begin
            scan_next      = '0;
            cmp_valid_next = 1'b0;
            state_next     = (used == '0) ? crs_pkg::ST_INSERT : crs_pkg::ST_SCAN;
          end else if (used == '0) begin
            state_next = crs_pkg::ST_PEND;
          end else if (fire) begin
            tick_next  = '0;
            state_next = crs_pkg::ST_FETCH;
          end else begin
            tick_next  = tick_inc[7:0];
            state_next = crs_pkg::ST_PEND;
          end
        end
      end

      crs_pkg::ST_SCAN: begin
        // one read issued and one entry compared per cycle
        rd_en          = issue;
        rd_addr        = scan[IDX_W-1:0];
        cmp_valid_next = issue;
        cmp_idx_next   = scan[IDX_W-1:0];
        if (issue) begin
          scan_next = scan + CNT_W'(1);
        end
        if (match) begin
          wr_en          = 1'b1;
          wr_addr        = cmp_idx;
          cmp_valid_next = 1'b0;
          state_next     = crs_pkg::ST_PEND;
        end else if (!issue && !cmp_valid) begin
          state_next = crs_pkg::ST_INSERT;
        end
      end

      crs_pkg::ST_INSERT: begin
        if (full) begin
          dropped_next = 1'b1;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = used[IDX_W-1:0];
          used_next = used + CNT_W'(1);
        end
        state_next = crs_pkg::ST_PEND;
      end

      crs_pkg::ST_FETCH: begin
        rd_en      = 1'b1;
        state_next = crs_pkg::ST_EVAL;
      end

      crs_pkg::ST_EVAL: begin
        compared_next = 1'b1;
        if (!item.bank_ok) begin
          // bank select failed: report the expected value, pointer stays
          healthy_next      = 1'b0;
          last_failure_next = {rd_data.bank_num, rd_data.reg_num, rd_data.value};
        end else if (first_bad && second_bad) begin
          // both reads bad: ask for a rewrite, pointer stays
          healthy_next      = 1'b0;
          rewrite_next      = 1'b1;
          restore_next      = rd_data.value;
          last_failure_next = {rd_data.bank_num, rd_data.reg_num,
                               item.first_read_ok ? item.first_read_value : 8'd0};
        end else if (ptr_inc == (CNT_W+1)'(used)) begin
          pointer_next = '0;
        end else begin
          pointer_next = ptr_inc[IDX_W-1:0];
        end
        state_next = crs_pkg::ST_PEND;
      end

      crs_pkg::ST_PEND: begin
        // fetch the entry the next check will examine
        rd_en      = 1'b1;
        state_next = crs_pkg::ST_DONE;
      end

      crs_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = crs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = crs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/checked_register_scrubber.sv =====
// Top level of the checked register scrubber: stream ports and result register.
// A record request searches the table one entry per cycle through the single
// read port of the entry memory; a check tick goes straight to a read of the
// next pending entry when the table is empty or the divider does not fire, and
// when it fires it steps through fetch, evaluate, then a read of the next
// pending entry. One request is in work at a time; a new request is taken as
// soon as the previous result sits in the output register, even if that result
// has not been taken yet. A configuration write is taken only between requests
// and goes ahead of a request offered in the same cycle. Writing table_capacity
// empties the table at once.
`default_nettype none

module checked_register_scrubber #(
  parameter int TABLE_DEPTH = crs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // bank_num[7:0], reg_num[15:8], expected_value[23:16], bank_ok[24],
  // first_read_ok[25], first_read_value[33:26], second_read_ok[34],
  // second_read_value[42:35], zero fill[47:43]
  input  wire logic [crs_pkg::S_TDATA_W-1:0] s_tdata,
  // opcode[0]
  input  wire logic                          s_tuser,
  // result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // healthy[0], compared[1], dropped[2], rewrite_request[3], fail_bank[11:4],
  // fail_reg[19:12], fail_value[27:20], restore_value[35:28],
  // pending_bank[43:36], pending_reg[51:44], zero fill[55:52]
  output logic [crs_pkg::M_TDATA_W-1:0]      m_tdata,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [7:0]                    cfg_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  crs_pkg::item_t   in_item;
  crs_pkg::result_t res;
  crs_pkg::entry_t  rd_data;
  crs_pkg::entry_t  wr_data;
  logic             res_valid;
  logic             res_ready;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;

  // Unpack request
  always_comb begin
    in_item.opcode            = s_tuser;
    in_item.bank_num          = s_tdata[7:0];
    in_item.reg_num           = s_tdata[15:8];
    in_item.expected_value    = s_tdata[23:16];
    in_item.bank_ok           = s_tdata[24];
    in_item.first_read_ok     = s_tdata[25];
    in_item.first_read_value  = s_tdata[33:26];
    in_item.second_read_ok    = s_tdata[34];
    in_item.second_read_value = s_tdata[42:35];
  end

  crs_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  crs_table_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Output register: loads when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {4'd0, res.pending_reg, res.pending_bank, res.restore_value,
                  res.fail_value, res.fail_reg, res.fail_bank,
                  res.rewrite_request, res.dropped, res.compared, res.healthy};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/crs_checker.sv =====
// Port-level checks on the result stream of the scrubber, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module crs_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [crs_pkg::M_TDATA_W-1:0] m_tdata
);

  // Output register is empty right after reset
  `CRS_ASSERT_IMPL(a_empty_after_rst, $fell(rst), !m_tvalid, "result valid after reset")

  // A stalled result holds
  `CRS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

  // Only an examined entry can be unhealthy
  `CRS_ASSERT_IMPL(a_fail_needs_compare, m_tvalid && !m_tdata[0], m_tdata[1], "failure without compare")

  // A rewrite request is always a failure, and restore is zero without one
  `CRS_ASSERT_IMPL(a_rewrite_fail, m_tvalid && m_tdata[3], !m_tdata[0], "rewrite on healthy result")
  `CRS_ASSERT_IMPL(a_restore_zero, m_tvalid && !m_tdata[3], m_tdata[35:28] == 8'd0, "restore without rewrite")

endmodule

bind checked_register_scrubber crs_checker u_crs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
